[sv/triangle_scanline_span_generator_top_assert.svh]
// ----------------------------------------------------------------------------
// Triangle span generator assertion macros
// Concurrent check wrappers used by the block's top level.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_SCANLINE_SPAN_GENERATOR_TOP_ASSERT_SVH
`define TRIANGLE_SCANLINE_SPAN_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define TSSG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tssg: same-cycle check failed");

// next-cycle implication
`define TSSG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tssg: next-cycle check failed");

`endif

[sv/tssg_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle span generator package
// Shared constants, codes and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package tssg_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int COLOR_BITS         = 32;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_UPPER = 2'd1,
      PH_LOWER = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_SPLIT_GO,
      CS_SPLIT_WAIT,
      CS_SPAN_WAIT,
      CS_WRITE_SPAN,
      CS_WRITE_NONE
   } ctrl_state_type;

   typedef enum logic [2:0] {
      ES_IDLE,
      ES_MAC,
      ES_PREP,
      ES_DIV,
      ES_FIN
   } edge_stage_type;

   typedef struct packed {
      logic load;
      logic start_split;
      logic commit_split;
      logic start_span;
      logic write_span;
      logic write_none;
   } cmd_type;

   typedef struct packed {
      logic phase_active;
      logic degenerate;
      logic split_done;
      logic span_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[sv/tssg_if.sv]
// ----------------------------------------------------------------------------
// Triangle span generator channels
// Valid/ready interfaces for the request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface tssg_req_if #(
   parameter int COORD_BITS = tssg_pkg::COORD_BITS_DEFAULT
);
   import tssg_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          action;
   logic signed [COORD_BITS-1:0]  vertex_a_x;
   logic signed [COORD_BITS-1:0]  vertex_a_y;
   logic signed [COORD_BITS-1:0]  vertex_b_x;
   logic signed [COORD_BITS-1:0]  vertex_b_y;
   logic signed [COORD_BITS-1:0]  vertex_c_x;
   logic signed [COORD_BITS-1:0]  vertex_c_y;
   logic [COLOR_BITS-1:0]         fill_value;

   modport source (
      output valid, action, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
             vertex_c_x, vertex_c_y, fill_value,
      input  ready
   );

   modport sink (
      input  valid, action, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
             vertex_c_x, vertex_c_y, fill_value,
      output ready
   );
endinterface

interface tssg_rsp_if #(
   parameter int COORD_BITS = tssg_pkg::COORD_BITS_DEFAULT
);
   import tssg_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [COORD_BITS-1:0]  row;
   logic signed [COORD_BITS-1:0]  span_start;
   logic signed [COORD_BITS-1:0]  span_end;
   logic [COLOR_BITS-1:0]         span_color;
   logic                          last_span;
   logic                          no_span;

   modport source (
      output valid, row, span_start, span_end, span_color, last_span, no_span,
      input  ready
   );

   modport sink (
      input  valid, row, span_start, span_end, span_color, last_span, no_span,
      output ready
   );
endinterface

`default_nettype wire

[sv/tssg_edge.sv]
// ----------------------------------------------------------------------------
// Triangle span generator edge unit
// Interpolates one edge x at a row: multiply-accumulate, then a restoring
// divider with round-half-away-from-zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tssg_edge #(
   parameter int COORD_BITS = tssg_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [COORD_BITS-1:0] x_from,
   input  logic signed [COORD_BITS-1:0] x_to,
   input  logic [COORD_BITS-1:0]        y_len,
   input  logic [COORD_BITS-1:0]        span,
   output logic                         done,
   output logic signed [COORD_BITS-1:0] result
);
   import tssg_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int NW = 2 * C + 2;
   localparam int CW = $clog2(C + 2);

   edge_stage_type        stage_ff, stage_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic signed [NW-1:0]  prod_ff, prod_in;
   logic signed [NW-1:0]  acc_ff, acc_in;
   logic signed [C:0]     dx_ff, dx_in;
   logic [C-1:0]          t_ff, t_in;
   logic [C-1:0]          d_ff, d_in;
   logic                  neg_ff, neg_in;
   logic [C:0]            rem_ff, rem_in;
   logic [C:0]            quo_ff, quo_in;
   logic signed [C-1:0]   result_ff, result_in;
   logic                  done_ff, done_in;

   logic [NW-1:0]         mag;
   logic [NW-1:0]         num;
   logic [C+1:0]          trial;
   logic [C+1:0]          dvs;
   logic [C+1:0]          diff;
   logic                  ge;
   logic [C:0]            signed_q;

   always_comb begin
      stage_in  = stage_ff;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      dx_in     = dx_ff;
      t_in      = t_ff;
      d_in      = d_ff;
      neg_in    = neg_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      result_in = result_ff;
      done_in   = 1'b0;

      mag      = acc_ff[NW-1] ? NW'(-acc_ff) : NW'(acc_ff);
      num      = {mag[NW-2:0], 1'b0} + {{(NW-C){1'b0}}, d_ff};
      trial    = {rem_ff, quo_ff[C]};
      dvs      = {1'b0, d_ff, 1'b0};
      ge       = (trial >= dvs);
      diff     = trial - dvs;
      signed_q = neg_ff ? (C+1)'(-quo_ff) : quo_ff;

      if (start) begin
         prod_in  = $signed({{(NW-C){x_from[C-1]}}, x_from})
                  * $signed({{(NW-C){1'b0}}, y_len});
         dx_in    = {x_to[C-1], x_to} - {x_from[C-1], x_from};
         t_in     = span;
         d_in     = y_len;
         stage_in = ES_MAC;
      end else begin
         unique case (stage_ff)
            ES_MAC: begin
               acc_in   = prod_ff + $signed({{(NW-C-1){dx_ff[C]}}, dx_ff})
                        * $signed({{(NW-C){1'b0}}, t_ff});
               stage_in = ES_PREP;
            end
            ES_PREP: begin
               neg_in   = acc_ff[NW-1];
               rem_in   = num[2*C+1:C+1];
               quo_in   = num[C:0];
               cnt_in   = CW'(C + 1);
               stage_in = ES_DIV;
            end
            ES_DIV: begin
               rem_in = ge ? diff[C:0] : trial[C:0];
               quo_in = {quo_ff[C-1:0], ge};
               cnt_in = cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  stage_in = ES_FIN;
               end
            end
            ES_FIN: begin
               result_in = signed_q[C-1:0];
               done_in   = 1'b1;
               stage_in  = ES_IDLE;
            end
            default: begin
               stage_in = ES_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= ES_IDLE;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      cnt_ff    <= cnt_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      dx_ff     <= dx_in;
      t_ff      <= t_in;
      d_ff      <= d_in;
      neg_ff    <= neg_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

[sv/tssg_ctrl.sv]
// ----------------------------------------------------------------------------
// Triangle span generator controller
// Sequences load, split-point interpolation, span interpolation and the
// response write.
// ----------------------------------------------------------------------------
`default_nettype none

module tssg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_ready,
   input  tssg_pkg::status_type status,
   output tssg_pkg::cmd_type    cmd
);
   import tssg_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ACT_LOAD) begin
                  cmd.load = 1'b1;
                  state_in = CS_SPLIT_GO;
               end else if (status.phase_active) begin
                  cmd.start_span = 1'b1;
                  state_in       = CS_SPAN_WAIT;
               end else begin
                  state_in = CS_WRITE_NONE;
               end
            end
         end
         CS_SPLIT_GO: begin
            if (status.degenerate) begin
               state_in = CS_IDLE;
            end else begin
               cmd.start_split = 1'b1;
               state_in        = CS_SPLIT_WAIT;
            end
         end
         CS_SPLIT_WAIT: begin
            if (status.split_done) begin
               cmd.commit_split = 1'b1;
               state_in         = CS_IDLE;
            end
         end
         CS_SPAN_WAIT: begin
            if (status.span_done) begin
               state_in = CS_WRITE_SPAN;
            end
         end
         CS_WRITE_SPAN: begin
            if (status.out_free) begin
               cmd.write_span = 1'b1;
               state_in       = CS_IDLE;
            end
         end
         CS_WRITE_NONE: begin
            if (status.out_free) begin
               cmd.write_none = 1'b1;
               state_in       = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[sv/tssg_dp.sv]
// ----------------------------------------------------------------------------
// Triangle span generator datapath
// Vertex sort, triangle state, edge units u_edge0 and u_edge1 and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module tssg_dp #(
   parameter int COORD_BITS = tssg_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tssg_pkg::cmd_type                   cmd,
   output tssg_pkg::status_type                status,
   input  logic signed [COORD_BITS-1:0]        req_vertex_a_x,
   input  logic signed [COORD_BITS-1:0]        req_vertex_a_y,
   input  logic signed [COORD_BITS-1:0]        req_vertex_b_x,
   input  logic signed [COORD_BITS-1:0]        req_vertex_b_y,
   input  logic signed [COORD_BITS-1:0]        req_vertex_c_x,
   input  logic signed [COORD_BITS-1:0]        req_vertex_c_y,
   input  logic [tssg_pkg::COLOR_BITS-1:0]     req_fill_value,
   tssg_rsp_if.source                          rsp_ch
);
   import tssg_pkg::*;

   localparam int C = COORD_BITS;

   logic signed [C-1:0]   top_x_ff, top_x_in, top_y_ff, top_y_in;
   logic signed [C-1:0]   mid_x_ff, mid_x_in, mid_y_ff, mid_y_in;
   logic signed [C-1:0]   bot_x_ff, bot_x_in, bot_y_ff, bot_y_in;
   logic signed [C-1:0]   split_x_ff, split_x_in;
   logic signed [C-1:0]   cur_row_ff, cur_row_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   phase_type             phase_ff, phase_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [C-1:0]   rsp_row_ff, rsp_row_in;
   logic signed [C-1:0]   rsp_start_ff, rsp_start_in;
   logic signed [C-1:0]   rsp_end_ff, rsp_end_in;
   logic [COLOR_BITS-1:0] rsp_color_ff, rsp_color_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_none_ff, rsp_none_in;

   // sort network
   logic signed [C-1:0]   s1_px, s1_py, s1_qx, s1_qy;
   logic signed [C-1:0]   s2_qx, s2_qy, s2_rx, s2_ry;
   logic signed [C-1:0]   s3_px, s3_py, s3_qx, s3_qy;

   logic [C:0]            dy_mt, dy_bt, dy_bm, dy_ct, dy_bc;
   logic                  top_is_mid;
   logic signed [C-1:0]   l0_from, l0_to, l1_from, l1_to;
   logic [C-1:0]          l_dist, l_span;
   logic                  l0_start, l1_start;
   logic                  l0_done, l1_done;
   logic signed [C-1:0]   l0_result, l1_result;
   logic                  last;

   always_comb begin
      if (req_vertex_a_y > req_vertex_b_y) begin
         s1_px = req_vertex_b_x; s1_py = req_vertex_b_y;
         s1_qx = req_vertex_a_x; s1_qy = req_vertex_a_y;
      end else begin
         s1_px = req_vertex_a_x; s1_py = req_vertex_a_y;
         s1_qx = req_vertex_b_x; s1_qy = req_vertex_b_y;
      end
      if (s1_qy > req_vertex_c_y) begin
         s2_qx = req_vertex_c_x; s2_qy = req_vertex_c_y;
         s2_rx = s1_qx;          s2_ry = s1_qy;
      end else begin
         s2_qx = s1_qx;          s2_qy = s1_qy;
         s2_rx = req_vertex_c_x; s2_ry = req_vertex_c_y;
      end
      if (s1_py > s2_qy) begin
         s3_px = s2_qx; s3_py = s2_qy;
         s3_qx = s1_px; s3_qy = s1_py;
      end else begin
         s3_px = s1_px; s3_py = s1_py;
         s3_qx = s2_qx; s3_qy = s2_qy;
      end
   end

   always_comb begin
      dy_mt    = {mid_y_ff[C-1], mid_y_ff} - {top_y_ff[C-1], top_y_ff};
      dy_bt    = {bot_y_ff[C-1], bot_y_ff} - {top_y_ff[C-1], top_y_ff};
      dy_bm    = {bot_y_ff[C-1], bot_y_ff} - {mid_y_ff[C-1], mid_y_ff};
      dy_ct    = {cur_row_ff[C-1], cur_row_ff} - {top_y_ff[C-1], top_y_ff};
      dy_bc    = {bot_y_ff[C-1], bot_y_ff} - {cur_row_ff[C-1], cur_row_ff};
      top_is_mid = (top_y_ff == mid_y_ff);

      if (cmd.start_split) begin
         l0_from = top_x_ff;
         l0_to   = bot_x_ff;
         l1_from = top_x_ff;
         l1_to   = bot_x_ff;
         l_dist  = dy_bt[C-1:0];
         l_span  = dy_mt[C-1:0];
      end else if (phase_ff == PH_UPPER) begin
         l0_from = top_x_ff;
         l0_to   = mid_x_ff;
         l1_from = top_x_ff;
         l1_to   = split_x_ff;
         l_dist  = dy_mt[C-1:0];
         l_span  = dy_ct[C-1:0];
      end else begin
         l0_from = bot_x_ff;
         l0_to   = top_is_mid ? top_x_ff : mid_x_ff;
         l1_from = bot_x_ff;
         l1_to   = top_is_mid ? mid_x_ff : split_x_ff;
         l_dist  = dy_bm[C-1:0];
         l_span  = dy_bc[C-1:0];
      end
      l0_start = cmd.start_split | cmd.start_span;
      l1_start = cmd.start_span;
   end

   tssg_edge #(.COORD_BITS(C)) u_edge0 (
      .clock  (clock),
      .reset  (reset),
      .start  (l0_start),
      .x_from (l0_from),
      .x_to   (l0_to),
      .y_len  (l_dist),
      .span   (l_span),
      .done   (l0_done),
      .result (l0_result)
   );

   tssg_edge #(.COORD_BITS(C)) u_edge1 (
      .clock  (clock),
      .reset  (reset),
      .start  (l1_start),
      .x_from (l1_from),
      .x_to   (l1_to),
      .y_len  (l_dist),
      .span   (l_span),
      .done   (l1_done),
      .result (l1_result)
   );

   always_comb begin
      top_x_in     = top_x_ff;
      top_y_in     = top_y_ff;
      mid_x_in     = mid_x_ff;
      mid_y_in     = mid_y_ff;
      bot_x_in     = bot_x_ff;
      bot_y_in     = bot_y_ff;
      split_x_in   = split_x_ff;
      cur_row_in   = cur_row_ff;
      color_in     = color_ff;
      phase_in     = phase_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_none_in  = rsp_none_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      last         = 1'b0;

      if (cmd.load) begin
         top_x_in   = s3_px;
         top_y_in   = s3_py;
         mid_x_in   = s3_qx;
         mid_y_in   = s3_qy;
         bot_x_in   = s2_rx;
         bot_y_in   = s2_ry;
         split_x_in = s2_rx;
         color_in   = req_fill_value;
         if (s3_py == s2_ry) begin
            phase_in = PH_IDLE;
         end else if (s3_py < s3_qy) begin
            phase_in   = PH_UPPER;
            cur_row_in = s3_py;
         end else begin
            phase_in   = PH_LOWER;
            cur_row_in = s2_ry;
         end
      end

      if (cmd.commit_split) begin
         split_x_in = l0_result;
      end

      if (cmd.write_span) begin
         if (phase_ff == PH_UPPER) begin
            if (cur_row_ff >= mid_y_ff) begin
               if (mid_y_ff < bot_y_ff) begin
                  phase_in   = PH_LOWER;
                  cur_row_in = bot_y_ff;
               end else begin
                  phase_in = PH_IDLE;
                  last     = 1'b1;
               end
            end else begin
               cur_row_in = cur_row_ff + C'(1);
            end
         end else begin
            if (cur_row_ff <= mid_y_ff) begin
               phase_in = PH_IDLE;
               last     = 1'b1;
            end else begin
               cur_row_in = cur_row_ff - C'(1);
            end
         end
         rsp_valid_in = 1'b1;
         rsp_row_in   = cur_row_ff;
         rsp_start_in = l0_result;
         rsp_end_in   = l1_result;
         rsp_color_in = color_ff;
         rsp_last_in  = last;
         rsp_none_in  = 1'b0;
      end

      if (cmd.write_none) begin
         phase_in     = PH_IDLE;
         rsp_valid_in = 1'b1;
         rsp_row_in   = '0;
         rsp_start_in = '0;
         rsp_end_in   = '0;
         rsp_color_in = '0;
         rsp_last_in  = 1'b0;
         rsp_none_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_x_ff     <= top_x_in;
      top_y_ff     <= top_y_in;
      mid_x_ff     <= mid_x_in;
      mid_y_ff     <= mid_y_in;
      bot_x_ff     <= bot_x_in;
      bot_y_ff     <= bot_y_in;
      split_x_ff   <= split_x_in;
      cur_row_ff   <= cur_row_in;
      color_ff     <= color_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_none_ff  <= rsp_none_in;
   end

   always_comb begin
      status.phase_active = (phase_ff == PH_UPPER) || (phase_ff == PH_LOWER);
      status.degenerate   = (top_y_ff == bot_y_ff);
      status.split_done   = l0_done;
      status.span_done    = l0_done & l1_done;
      status.out_free     = ~rsp_valid_ff | rsp_ch.ready;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.row        = rsp_row_ff;
   assign rsp_ch.span_start = rsp_start_ff;
   assign rsp_ch.span_end   = rsp_end_ff;
   assign rsp_ch.span_color = rsp_color_ff;
   assign rsp_ch.last_span  = rsp_last_ff;
   assign rsp_ch.no_span    = rsp_none_ff;

endmodule

`default_nettype wire

[sv/triangle_scanline_span_generator_top.sv]
// ----------------------------------------------------------------------------
// Triangle scanline span generator
// Splits a triangle into flat-top and flat-bottom halves and emits one
// horizontal span, or a no_span word, per step request.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries load words (three vertices and a color) and step words.
//   A load sorts the vertices by y and interpolates the split point; it
//   returns no response, and the next word is accepted once the split point
//   is stored (a triangle with zero height skips the split).
//   A step returns one word on rsp_ch: the next span, or no_span when no
//   span is pending. A span is interpolated by both edge units, each of
//   which retires one quotient bit per cycle, and is then written out.
//   A no_span word skips the edge units. One word is in work at a time.
//   The response sits in an output register, so the next word is accepted
//   while rsp_ch is stalled; a finished span then waits for the register.
//   Reset clears the sequencer and output valid; no span is pending after it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_scanline_span_generator_top_assert.svh"

module triangle_scanline_span_generator_top #(
   parameter int COORD_BITS = tssg_pkg::COORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   tssg_req_if.sink    req_ch,
   tssg_rsp_if.source  rsp_ch
);
   import tssg_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   tssg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   tssg_dp #(.COORD_BITS(COORD_BITS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_vertex_a_x (req_ch.vertex_a_x),
      .req_vertex_a_y (req_ch.vertex_a_y),
      .req_vertex_b_x (req_ch.vertex_b_x),
      .req_vertex_b_y (req_ch.vertex_b_y),
      .req_vertex_c_x (req_ch.vertex_c_x),
      .req_vertex_c_y (req_ch.vertex_c_y),
      .req_fill_value (req_ch.fill_value),
      .rsp_ch         (rsp_ch)
   );

   assign req_ch.ready = req_ready;

   `TSSG_ASSERT_NOW(a_no_span_zero, clock, reset, rsp_ch.valid && rsp_ch.no_span, rsp_ch.row == '0 && rsp_ch.span_start == '0 && rsp_ch.span_end == '0 && rsp_ch.span_color == '0 && !rsp_ch.last_span)
   `TSSG_ASSERT_NEXT(a_one_in_work, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   `TSSG_ASSERT_NOW(a_write_when_busy, clock, reset, $rose(rsp_ch.valid), $past(!req_ch.ready))

endmodule

`default_nettype wire
